FILE: rtl/dscw_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and zone tables for the sector chain writer
package dscw_pkg;

   // image geometry
   localparam int ADDR_BITS     = 18;
   localparam int MAX_TRACKS    = 42;
   localparam int TRACK_BITS    = 6;
   localparam int SECT_BITS     = 5;
   localparam int SIDX_BITS     = 10;
   localparam int BYTE_BITS     = 8;
   localparam int RAW_ADDR_BITS = 18;
   localparam int STATUS_BITS   = 2;

   localparam logic [TRACK_BITS-1:0] DIR_TRACK    = 6'd18;
   localparam logic [TRACK_BITS-1:0] RESET_TRACKS = 6'd35;
   localparam logic [TRACK_BITS-1:0] TRACK_LIMIT  = TRACK_BITS'(MAX_TRACKS);

   // header layout and marks
   localparam logic [BYTE_BITS-1:0] LINK_OFFS  = 8'h00;
   localparam logic [BYTE_BITS-1:0] LAST_OFFS  = 8'h01;
   localparam logic [BYTE_BITS-1:0] FIRST_DATA = 8'h02;
   localparam logic [BYTE_BITS-1:0] FULL_MARK  = 8'hFF;

   // allocation map lives in sector 18/0
   localparam logic [SIDX_BITS-1:0] DIR_SIDX = 10'd357;
   localparam logic [ADDR_BITS-1:0] DIR_BASE = ADDR_BITS'({DIR_SIDX, LINK_OFFS});

   typedef enum logic [1:0] {
      OP_WRITE_BYTE = 2'd0,
      OP_END_FILE   = 2'd1,
      OP_RAW_READ   = 2'd2,
      OP_RAW_WRITE  = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_BEYOND = 2'd2
   } status_type;

   // memory address source
   typedef enum logic [2:0] {
      AS_LINK   = 3'd0,
      AS_LAST   = 3'd1,
      AS_APPEND = 3'd2,
      AS_FIRST  = 3'd3,
      AS_BITS   = 3'd4,
      AS_COUNT  = 3'd5,
      AS_RAW    = 3'd6,
      AS_CLEAR  = 3'd7
   } addr_sel_type;

   // memory write data source
   typedef enum logic [2:0] {
      WS_ZERO        = 3'd0,
      WS_NEXT_TRACK  = 3'd1,
      WS_NEXT_SECTOR = 3'd2,
      WS_BYTE        = 3'd3,
      WS_LAST_INC    = 3'd4,
      WS_BITS_CLR    = 3'd5,
      WS_COUNT_DEC   = 3'd6,
      WS_FIRST_DATA  = 3'd7
   } wdata_sel_type;

   // controller to datapath
   typedef struct packed {
      logic          accept;
      logic          clear_step;
      logic          mem_rd;
      logic          mem_we;
      addr_sel_type  addr_sel;
      wdata_sel_type wdata_sel;
      logic          advance;
      logic          set_full;
      logic          set_beyond;
      logic          cap_read;
      logic          respond;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_full;
      logic last_zero;
      logic next_ok;
      logic bit_set;
      logic beyond;
      logic clear_last;
   } stat_type;

   // sectors on a track, zero for no track
   function automatic logic [SECT_BITS-1:0] sectors_per_track(input logic [TRACK_BITS-1:0] trk);
      logic [SECT_BITS-1:0] cnt;
      unique case (trk) inside
         [6'd1:6'd17]:  cnt = 5'd21;
         [6'd18:6'd24]: cnt = 5'd19;
         [6'd25:6'd30]: cnt = 5'd18;
         [6'd31:6'd42]: cnt = 5'd17;
         default:       cnt = 5'd0;
      endcase
      return cnt;
   endfunction

   // index of a track's first sector in the image, zero for no track
   function automatic logic [SIDX_BITS-1:0] first_sector(input logic [TRACK_BITS-1:0] trk);
      logic [SIDX_BITS-1:0] idx;
      unique case (trk)
         6'd1:  idx = 10'd0;    6'd2:  idx = 10'd21;   6'd3:  idx = 10'd42;
         6'd4:  idx = 10'd63;   6'd5:  idx = 10'd84;   6'd6:  idx = 10'd105;
         6'd7:  idx = 10'd126;  6'd8:  idx = 10'd147;  6'd9:  idx = 10'd168;
         6'd10: idx = 10'd189;  6'd11: idx = 10'd210;  6'd12: idx = 10'd231;
         6'd13: idx = 10'd252;  6'd14: idx = 10'd273;  6'd15: idx = 10'd294;
         6'd16: idx = 10'd315;  6'd17: idx = 10'd336;  6'd18: idx = 10'd357;
         6'd19: idx = 10'd376;  6'd20: idx = 10'd395;  6'd21: idx = 10'd414;
         6'd22: idx = 10'd433;  6'd23: idx = 10'd452;  6'd24: idx = 10'd471;
         6'd25: idx = 10'd490;  6'd26: idx = 10'd508;  6'd27: idx = 10'd526;
         6'd28: idx = 10'd544;  6'd29: idx = 10'd562;  6'd30: idx = 10'd580;
         6'd31: idx = 10'd598;  6'd32: idx = 10'd615;  6'd33: idx = 10'd632;
         6'd34: idx = 10'd649;  6'd35: idx = 10'd666;  6'd36: idx = 10'd683;
         6'd37: idx = 10'd700;  6'd38: idx = 10'd717;  6'd39: idx = 10'd734;
         6'd40: idx = 10'd751;  6'd41: idx = 10'd768;  6'd42: idx = 10'd785;
         default: idx = 10'd0;
      endcase
      return idx;
   endfunction

endpackage

FILE: rtl/dscw_ctrl.sv
`timescale 1ns / 1ps
// controller state machine: sequences memory accesses for each operation
module dscw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          req_op,
   input  dscw_pkg::stat_type  stat,
   output logic                busy,
   output dscw_pkg::cmd_type   cmd
);

   typedef enum logic [14:0] {
      S_CLEAR    = 15'b000000000000001,
      S_IDLE     = 15'b000000000000010,
      S_RD_HDR   = 15'b000000000000100,
      S_CHK_HDR  = 15'b000000000001000,
      S_LINK     = 15'b000000000010000,
      S_APP_HDR  = 15'b000000000100000,
      S_RD_BITS  = 15'b000000001000000,
      S_CHK_BITS = 15'b000000010000000,
      S_RD_CNT   = 15'b000000100000000,
      S_WR_CNT   = 15'b000001000000000,
      S_WR_DATA  = 15'b000010000000000,
      S_WR_HDR   = 15'b000100000000000,
      S_ADV      = 15'b001000000000000,
      S_RAW      = 15'b010000000000000,
      S_RAW_RD   = 15'b100000000000000
   } state_type;

   state_type        state_ff, state_in;
   dscw_pkg::op_type op_ff, op_in;

   // next state and command decode
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            cmd.mem_we     = 1'b1;
            cmd.addr_sel   = dscw_pkg::AS_CLEAR;
            cmd.wdata_sel  = dscw_pkg::WS_ZERO;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               op_in      = dscw_pkg::op_type'(req_op);
               case (dscw_pkg::op_type'(req_op)) inside
                  dscw_pkg::OP_WRITE_BYTE:                       state_in = S_RD_HDR;
                  dscw_pkg::OP_END_FILE:                         state_in = S_ADV;
                  dscw_pkg::OP_RAW_READ, dscw_pkg::OP_RAW_WRITE: state_in = S_RAW;
                  default:                                       state_in = S_IDLE;
               endcase
            end
         end
         S_RD_HDR: begin
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = dscw_pkg::AS_LAST;
            state_in     = S_CHK_HDR;
         end
         S_CHK_HDR: begin
            if (stat.last_full) begin
               if (stat.next_ok) begin
                  cmd.mem_we    = 1'b1;
                  cmd.addr_sel  = dscw_pkg::AS_LINK;
                  cmd.wdata_sel = dscw_pkg::WS_NEXT_TRACK;
                  state_in      = S_LINK;
               end else begin
                  cmd.set_full = 1'b1;
                  cmd.respond  = 1'b1;
                  state_in     = S_IDLE;
               end
            end else if (stat.last_zero) begin
               state_in = S_RD_BITS;
            end else begin
               cmd.mem_we    = 1'b1;
               cmd.addr_sel  = dscw_pkg::AS_APPEND;
               cmd.wdata_sel = dscw_pkg::WS_BYTE;
               state_in      = S_APP_HDR;
            end
         end
         S_LINK: begin
            // second link byte goes to the old sector, then the pointer moves
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = dscw_pkg::AS_LAST;
            cmd.wdata_sel = dscw_pkg::WS_NEXT_SECTOR;
            cmd.advance   = 1'b1;
            state_in      = S_RD_BITS;
         end
         S_APP_HDR: begin
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = dscw_pkg::AS_LAST;
            cmd.wdata_sel = dscw_pkg::WS_LAST_INC;
            cmd.respond   = 1'b1;
            state_in      = S_IDLE;
         end
         S_RD_BITS: begin
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = dscw_pkg::AS_BITS;
            state_in     = S_CHK_BITS;
         end
         S_CHK_BITS: begin
            if (stat.bit_set) begin
               cmd.mem_we    = 1'b1;
               cmd.addr_sel  = dscw_pkg::AS_BITS;
               cmd.wdata_sel = dscw_pkg::WS_BITS_CLR;
               state_in      = S_RD_CNT;
            end else begin
               state_in = S_WR_DATA;
            end
         end
         S_RD_CNT: begin
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = dscw_pkg::AS_COUNT;
            state_in     = S_WR_CNT;
         end
         S_WR_CNT: begin
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = dscw_pkg::AS_COUNT;
            cmd.wdata_sel = dscw_pkg::WS_COUNT_DEC;
            state_in      = S_WR_DATA;
         end
         S_WR_DATA: begin
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = dscw_pkg::AS_FIRST;
            cmd.wdata_sel = dscw_pkg::WS_BYTE;
            state_in      = S_WR_HDR;
         end
         S_WR_HDR: begin
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = dscw_pkg::AS_LAST;
            cmd.wdata_sel = dscw_pkg::WS_FIRST_DATA;
            cmd.respond   = 1'b1;
            state_in      = S_IDLE;
         end
         S_ADV: begin
            if (stat.next_ok) begin
               cmd.advance = 1'b1;
            end else begin
               cmd.set_full = 1'b1;
            end
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         S_RAW: begin
            if (stat.beyond) begin
               cmd.set_beyond = 1'b1;
               cmd.respond    = 1'b1;
               state_in       = S_IDLE;
            end else if (op_ff == dscw_pkg::OP_RAW_READ) begin
               cmd.mem_rd   = 1'b1;
               cmd.addr_sel = dscw_pkg::AS_RAW;
               state_in     = S_RAW_RD;
            end else begin
               cmd.mem_we    = 1'b1;
               cmd.addr_sel  = dscw_pkg::AS_RAW;
               cmd.wdata_sel = dscw_pkg::WS_BYTE;
               cmd.respond   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_RAW_RD: begin
            cmd.cap_read = 1'b1;
            cmd.respond  = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   // state register, clearing pass first after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // latched operation
   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

endmodule

FILE: rtl/dscw_datapath.sv
`timescale 1ns / 1ps
// datapath: image memory, write pointer, track count register and result registers
module dscw_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dscw_pkg::cmd_type                    cmd,
   output dscw_pkg::stat_type                   stat,
   input  logic [dscw_pkg::BYTE_BITS-1:0]       req_data_byte,
   input  logic [dscw_pkg::RAW_ADDR_BITS-1:0]   req_address,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dscw_pkg::TRACK_BITS-1:0]      csr_wdata,
   output logic                                 rsp_valid,
   output logic [dscw_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [dscw_pkg::BYTE_BITS-1:0]       rsp_read_data,
   output logic [dscw_pkg::TRACK_BITS-1:0]      rsp_track_now,
   output logic [dscw_pkg::SECT_BITS-1:0]       rsp_sector_now
);

   localparam int AB = dscw_pkg::ADDR_BITS;
   localparam int TB = dscw_pkg::TRACK_BITS;
   localparam int SB = dscw_pkg::SECT_BITS;
   localparam int BB = dscw_pkg::BYTE_BITS;
   localparam int IB = dscw_pkg::SIDX_BITS;

   logic [BB-1:0] image_ram [0:(1 << AB)-1];

   logic [TB-1:0]              num_tracks_ff, num_tracks_in;
   logic [TB-1:0]              cur_track_ff, cur_track_in;
   logic [SB-1:0]              cur_sector_ff, cur_sector_in;
   logic [BB-1:0]              byte_ff, byte_in;
   logic [dscw_pkg::RAW_ADDR_BITS-1:0] addr_ff, addr_in;
   dscw_pkg::status_type       status_ff, status_in;
   logic [BB-1:0]              rd_ff, rd_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [AB-1:0]              clr_ff, clr_in;
   logic [BB-1:0]              mem_q_ff;

   logic [TB-1:0] tracks_used;
   logic [SB-1:0] track_sectors;
   logic [SB:0]   sector_inc;
   logic [TB-1:0] next_track;
   logic [SB-1:0] next_sector;
   logic          next_ok;
   logic [IB-1:0] sector_idx;
   logic [IB-1:0] end_idx;
   logic [AB-1:0] count_addr;
   logic [AB-1:0] bits_addr;
   logic [BB-1:0] bit_mask;
   logic [BB-1:0] last_inc;
   logic [BB-1:0] count_dec;
   logic [AB-1:0] mem_addr;
   logic [BB-1:0] mem_wdata;

   // tracks in use, capped at the table size
   assign tracks_used = (num_tracks_ff > dscw_pkg::TRACK_LIMIT) ? dscw_pkg::TRACK_LIMIT
                                                                 : num_tracks_ff;

   // next physical sector, skipping the directory track
   always_comb begin
      track_sectors = dscw_pkg::sectors_per_track(cur_track_ff);
      sector_inc    = {1'b0, cur_sector_ff} + (SB+1)'(1);
      next_track    = cur_track_ff;
      next_sector   = cur_sector_ff;
      next_ok       = 1'b1;
      if ((track_sectors != '0) && (sector_inc < {1'b0, track_sectors})) begin
         next_sector = sector_inc[SB-1:0];
      end else if (cur_track_ff < tracks_used) begin
         next_track  = cur_track_ff + TB'(1);
         next_sector = '0;
      end else begin
         next_ok = 1'b0;
      end
      if (next_track == dscw_pkg::DIR_TRACK) begin
         next_track  = dscw_pkg::DIR_TRACK + TB'(1);
         next_sector = '0;
      end
   end

   // sector and map addressing
   assign sector_idx = dscw_pkg::first_sector(cur_track_ff) + IB'(cur_sector_ff);
   assign end_idx    = dscw_pkg::first_sector(tracks_used)
                     + IB'(dscw_pkg::sectors_per_track(tracks_used));
   assign count_addr = dscw_pkg::DIR_BASE + AB'({cur_track_ff, 2'b00});
   assign bits_addr  = count_addr + AB'(3'd1 + {1'b0, cur_sector_ff[SB-1:3]});
   assign bit_mask   = BB'(1) << cur_sector_ff[2:0];
   assign last_inc   = mem_q_ff + BB'(1);
   assign count_dec  = (mem_q_ff == '0) ? '0 : (mem_q_ff - BB'(1));

   // memory address select
   always_comb begin
      case (cmd.addr_sel)
         dscw_pkg::AS_LINK:   mem_addr = AB'({sector_idx, dscw_pkg::LINK_OFFS});
         dscw_pkg::AS_LAST:   mem_addr = AB'({sector_idx, dscw_pkg::LAST_OFFS});
         dscw_pkg::AS_APPEND: mem_addr = AB'({sector_idx, last_inc});
         dscw_pkg::AS_FIRST:  mem_addr = AB'({sector_idx, dscw_pkg::FIRST_DATA});
         dscw_pkg::AS_BITS:   mem_addr = bits_addr;
         dscw_pkg::AS_COUNT:  mem_addr = count_addr;
         dscw_pkg::AS_RAW:    mem_addr = AB'(addr_ff);
         dscw_pkg::AS_CLEAR:  mem_addr = clr_ff;
         default:             mem_addr = clr_ff;
      endcase
   end

   // memory write data select
   always_comb begin
      case (cmd.wdata_sel)
         dscw_pkg::WS_ZERO:        mem_wdata = '0;
         dscw_pkg::WS_NEXT_TRACK:  mem_wdata = BB'(next_track);
         dscw_pkg::WS_NEXT_SECTOR: mem_wdata = BB'(next_sector);
         dscw_pkg::WS_BYTE:        mem_wdata = byte_ff;
         dscw_pkg::WS_LAST_INC:    mem_wdata = last_inc;
         dscw_pkg::WS_BITS_CLR:    mem_wdata = mem_q_ff & ~bit_mask;
         dscw_pkg::WS_COUNT_DEC:   mem_wdata = count_dec;
         dscw_pkg::WS_FIRST_DATA:  mem_wdata = dscw_pkg::FIRST_DATA;
         default:                  mem_wdata = '0;
      endcase
   end

   // image memory, one access a cycle, registered read
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         image_ram[mem_addr] <= mem_wdata;
      end
      if (cmd.mem_rd) begin
         mem_q_ff <= image_ram[mem_addr];
      end
   end

   // status back to the controller
   assign stat.last_full  = (mem_q_ff == dscw_pkg::FULL_MARK);
   assign stat.last_zero  = (mem_q_ff == '0);
   assign stat.next_ok    = next_ok;
   assign stat.bit_set    = |(mem_q_ff & bit_mask);
   assign stat.beyond     = (addr_ff[dscw_pkg::RAW_ADDR_BITS-1:BB] >= end_idx);
   assign stat.clear_last = &clr_ff;

   // next values of the control and payload registers
   always_comb begin
      num_tracks_in = num_tracks_ff;
      cur_track_in  = cur_track_ff;
      cur_sector_in = cur_sector_ff;
      byte_in       = byte_ff;
      addr_in       = addr_ff;
      status_in     = status_ff;
      rd_in         = rd_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = cmd.respond;
      if (csr_valid && csr_ready) begin
         num_tracks_in = csr_wdata;
      end
      if (cmd.advance) begin
         cur_track_in  = next_track;
         cur_sector_in = next_sector;
      end
      if (cmd.accept) begin
         byte_in   = req_data_byte;
         addr_in   = req_address;
         status_in = dscw_pkg::ST_OK;
         rd_in     = '0;
      end
      if (cmd.set_full) begin
         status_in = dscw_pkg::ST_FULL;
      end
      if (cmd.set_beyond) begin
         status_in = dscw_pkg::ST_BEYOND;
      end
      if (cmd.cap_read) begin
         rd_in = mem_q_ff;
      end
      if (cmd.clear_step) begin
         clr_in = clr_ff + AB'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_tracks_ff <= dscw_pkg::RESET_TRACKS;
         cur_track_ff  <= TB'(1);
         cur_sector_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         clr_ff        <= '0;
      end else begin
         num_tracks_ff <= num_tracks_in;
         cur_track_ff  <= cur_track_in;
         cur_sector_ff <= cur_sector_in;
         rsp_valid_ff  <= rsp_valid_in;
         clr_ff        <= clr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      addr_ff   <= addr_in;
      status_ff <= status_in;
      rd_ff     <= rd_in;
   end

   // register port and result ports
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_read_data  = rd_ff;
   assign rsp_track_now  = cur_track_ff;
   assign rsp_sector_now = cur_sector_ff;

endmodule

FILE: rtl/disk_image_sector_chain_writer_unit.sv
`timescale 1ns / 1ps
// top level: sector chain writer over a zoned disk image with allocation map
//
// After reset the block runs a clearing pass over all 2**18 = 262144 image
// bytes, one byte a cycle, with busy high; the track count register can be
// written during that pass. An operation is taken when start is high and busy
// is low. All work goes through one single-port image memory with a registered
// read: an append inside a sector reads the header, then writes the byte and
// the raised header; the first byte of a fresh sector first links the old one
// when that was full, reads the map bits, clears a set free bit and lowers the
// count, then writes byte and header; end_file moves the pointer; raw ops one byte.
// The result is shown for one cycle with rsp_valid and cannot be stalled; busy
// is already low in that cycle, so the next operation may start there. The
// track count register should be written only while busy is low.
module disk_image_sector_chain_writer_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_op,
   input  logic [dscw_pkg::BYTE_BITS-1:0]       req_data_byte,
   input  logic [dscw_pkg::RAW_ADDR_BITS-1:0]   req_address,
   output logic                                 rsp_valid,
   output logic [dscw_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic [dscw_pkg::BYTE_BITS-1:0]       rsp_read_data,
   output logic [dscw_pkg::TRACK_BITS-1:0]      rsp_track_now,
   output logic [dscw_pkg::SECT_BITS-1:0]       rsp_sector_now,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dscw_pkg::TRACK_BITS-1:0]      csr_wdata
);

   dscw_pkg::cmd_type  cmd;
   dscw_pkg::stat_type stat;

   // controller
   dscw_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .stat   (stat),
      .busy   (busy),
      .cmd    (cmd)
   );

   // datapath
   dscw_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_data_byte  (req_data_byte),
      .req_address    (req_address),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_read_data  (rsp_read_data),
      .rsp_track_now  (rsp_track_now),
      .rsp_sector_now (rsp_sector_now)
   );

   // results are strobes of a single cycle
   ap_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // a result transfer leaves the block ready for the next operation
   ap_ready_at_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("block still busy while showing a result");

   // no memory write while idle
   ap_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !cmd.mem_we)
      else $error("image written while idle");

   // the write pointer never rests on the directory track
   ap_pointer_off_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_track_now != dscw_pkg::DIR_TRACK))
      else $error("write pointer on directory track");

   // a rejected raw access returns no data
   ap_beyond_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == dscw_pkg::ST_BEYOND)) |-> (rsp_read_data == '0))
      else $error("data returned for address beyond image");

endmodule

FILE: dv/tb_disk_image_sector_chain_writer_unit.sv
`timescale 1ns / 1ps
// testbench for the sector chain writer: directed ops, random traffic and chain walks to disk full
module tb_disk_image_sector_chain_writer_unit;

   localparam int IMG_BYTES      = 1 << 18;
   localparam int IMG_MASK       = IMG_BYTES - 1;
   localparam int TRACK_CAP      = 42;
   localparam int DIR_TRK        = 18;
   localparam int SECTOR_BYTES   = 256;
   localparam int MAP_BYTES      = 172;
   localparam logic [7:0] SECTOR_FULL    = 8'hFF;
   localparam logic [7:0] FIRST_DATA_IDX = 8'h02;
   // longest quiet stretch is the clearing pass after reset, taken three times over
   localparam int QUIET_LIMIT    = 800000;

   typedef struct packed {
      dscw_pkg::status_type status;
      logic [7:0]           read_data;
      logic [5:0]           track;
      logic [4:0]           sector;
   } op_outcome_type;

   logic        clock;
   logic        reset         = 1'b1;
   logic        start         = 1'b0;
   logic        busy;
   logic [1:0]  req_op        = '0;
   logic [7:0]  req_data_byte = '0;
   logic [17:0] req_address   = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_read_data;
   logic [5:0]  rsp_track_now;
   logic [4:0]  rsp_sector_now;
   logic        csr_valid     = 1'b0;
   logic        csr_ready;
   logic [5:0]  csr_wdata     = '0;

   // mirror of the image, pointer and track count
   logic [7:0]  img_mirror [IMG_BYTES];
   int          trk_count_mirror;
   int          ptr_track;
   int          ptr_sector;

   op_outcome_type outcomes_due [$];
   int          mismatch_count = 0;
   int          quiet_cycles   = 0;
   int          idle_pct       = 0;
   int          drain_pct      = 0;

   disk_image_sector_chain_writer_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_data_byte  (req_data_byte),
      .req_address    (req_address),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_read_data  (rsp_read_data),
      .rsp_track_now  (rsp_track_now),
      .rsp_sector_now (rsp_sector_now),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // zone layout
   function automatic int zone_sectors(input int trk);
      if (trk >= 1 && trk <= 17) return 21;
      if (trk >= 18 && trk <= 24) return 19;
      if (trk >= 25 && trk <= 30) return 18;
      if (trk >= 31 && trk <= TRACK_CAP) return 17;
      return 0;
   endfunction

   function automatic int zone_base(input int trk);
      int idx = 0;
      if (trk > TRACK_CAP) return 0;
      for (int k = 1; k < trk; k++) idx += zone_sectors(k);
      return idx;
   endfunction

   function automatic int tracks_used();
      return (trk_count_mirror > TRACK_CAP) ? TRACK_CAP : trk_count_mirror;
   endfunction

   function automatic int sector_start(input int t, input int s);
      int trk;
      trk = (t > TRACK_CAP) ? 0 : t;
      return ((zone_base(trk) + (s & 31)) * SECTOR_BYTES) & IMG_MASK;
   endfunction

   function automatic int image_limit();
      int n;
      n = tracks_used();
      if (n == 0) return 0;
      return (zone_base(n) + zone_sectors(n)) * SECTOR_BYTES;
   endfunction

   // next physical sector, hopping over the directory track
   function automatic bit next_after(input int t, input int s, output int nxt_t,
                                     output int nxt_s);
      int cnt;
      cnt = (t <= TRACK_CAP) ? zone_sectors(t) : 0;
      nxt_t = t;
      nxt_s = s;
      if (cnt > 0 && s + 1 < cnt) begin
         s = s + 1;
      end else if (t < tracks_used()) begin
         t = t + 1;
         s = 0;
      end else begin
         return 1'b0;
      end
      if (t == DIR_TRK) begin
         t = DIR_TRK + 1;
         s = 0;
      end
      nxt_t = t;
      nxt_s = s;
      return 1'b1;
   endfunction

   // if the free bit is set, clear it and lower the count unless already zero
   task automatic mark_map_used(input int t, input int s);
      int cnt_at;
      int bits_at;
      logic [7:0] bit_mask;
      cnt_at   = (sector_start(DIR_TRK, 0) + 4 * (t & 63)) & IMG_MASK;
      bits_at  = (cnt_at + 1 + ((s & 31) >> 3)) & IMG_MASK;
      bit_mask = 8'(1 << (s & 7));
      if ((img_mirror[bits_at] & bit_mask) != 0) begin
         img_mirror[bits_at] = img_mirror[bits_at] & ~bit_mask;
         if (img_mirror[cnt_at] != 0) img_mirror[cnt_at] = img_mirror[cnt_at] - 8'd1;
      end
   endtask

   // outcome of one operation on the mirrored image
   task automatic apply_image_op(input dscw_pkg::op_type op, input logic [7:0] dbyte,
                                 input logic [17:0] addr, output op_outcome_type res);
      int t, s, nxt_t, nxt_s, pos, last;
      bit ok;
      res.status    = dscw_pkg::ST_OK;
      res.read_data = 8'h00;
      case (op)
         dscw_pkg::OP_WRITE_BYTE: begin
            t    = ptr_track;
            s    = ptr_sector;
            pos  = sector_start(t, s);
            last = img_mirror[(pos + 1) & IMG_MASK];
            ok   = 1'b1;
            // full sector: move on and leave a link in the old header
            if (last == SECTOR_FULL) begin
               if (!next_after(t, s, nxt_t, nxt_s)) begin
                  ok         = 1'b0;
                  res.status = dscw_pkg::ST_FULL;
               end else begin
                  img_mirror[pos]                  = 8'(nxt_t);
                  img_mirror[(pos + 1) & IMG_MASK] = 8'(nxt_s);
                  t    = nxt_t;
                  s    = nxt_s;
                  pos  = sector_start(t, s);
                  last = 0;
               end
            end
            if (ok) begin
               if (last == 0) begin
                  mark_map_used(t, s);
                  img_mirror[(pos + 2) & IMG_MASK] = dbyte;
                  img_mirror[(pos + 1) & IMG_MASK] = FIRST_DATA_IDX;
               end else begin
                  last = last + 1;
                  img_mirror[(pos + last) & IMG_MASK] = dbyte;
                  img_mirror[(pos + 1) & IMG_MASK]    = 8'(last);
               end
               ptr_track  = t;
               ptr_sector = s;
            end
         end
         dscw_pkg::OP_END_FILE: begin
            if (next_after(ptr_track, ptr_sector, nxt_t, nxt_s)) begin
               ptr_track  = nxt_t;
               ptr_sector = nxt_s;
            end else begin
               res.status = dscw_pkg::ST_FULL;
            end
         end
         default: begin
            if (int'(addr) >= image_limit()) res.status = dscw_pkg::ST_BEYOND;
            else if (op == dscw_pkg::OP_RAW_READ) res.read_data = img_mirror[addr];
            else img_mirror[addr] = dbyte;
         end
      endcase
      res.track  = 6'(ptr_track);
      res.sector = 5'(ptr_sector);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
   endtask

   // one operation transfer, with optional gap or drain first
   task automatic issue_op(input dscw_pkg::op_type op, input logic [7:0] dbyte,
                           input logic [17:0] addr, output op_outcome_type res);
      int gap;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         gap = $urandom_range(12, 1);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (drain_pct > 0 && $urandom_range(99) < drain_pct) begin
         start <= 1'b0;
         do @(posedge clock); while (outcomes_due.size() != 0);
      end
      start         <= 1'b1;
      req_op        <= op;
      req_data_byte <= dbyte;
      req_address   <= addr;
      do @(posedge clock); while (busy);
      apply_image_op(op, dbyte, addr, res);
      outcomes_due.push_back(res);
   endtask

   task automatic quiesce();
      start <= 1'b0;
      do @(posedge clock); while (outcomes_due.size() != 0 || busy);
   endtask

   task automatic set_track_count(input logic [5:0] n);
      quiesce();
      csr_valid <= 1'b1;
      csr_wdata <= n;
      do @(posedge clock); while (!csr_ready);
      trk_count_mirror = n;
      csr_valid <= 1'b0;
   endtask

   // raw addresses: anywhere, allocation map, current sector, image end
   function automatic logic [17:0] aim_raw_addr();
      int sel;
      sel = $urandom_range(9);
      case (sel)
         4, 5:    return 18'(sector_start(DIR_TRK, 0) + $urandom_range(MAP_BYTES - 1));
         6, 7:    return 18'(sector_start(ptr_track, ptr_sector) + $urandom_range(255));
         8:       return 18'(image_limit() - 1 + $urandom_range(1));
         default: return 18'($urandom);
      endcase
   endfunction

   // header fill levels, mostly ones that push a sector to or past its end
   function automatic logic [7:0] fill_level();
      int sel;
      sel = $urandom_range(19);
      if (sel < 8) return 8'hFE;
      if (sel < 13) return SECTOR_FULL;
      if (sel < 15) return 8'h01;
      if (sel < 16) return 8'h00;
      return 8'($urandom);
   endfunction

   task automatic test_directed_ops();
      op_outcome_type res;
      int map_at, end_at, hdr_at;
      map_at = sector_start(DIR_TRK, 0) + 4;
      end_at = image_limit();
      // raw access at both ends of the image and past it
      issue_op(dscw_pkg::OP_RAW_READ,  8'h00, 18'd0, res);
      issue_op(dscw_pkg::OP_RAW_WRITE, 8'h00, 18'd0, res);
      issue_op(dscw_pkg::OP_RAW_READ,  8'h00, 18'(end_at - 1), res);
      issue_op(dscw_pkg::OP_RAW_READ,  8'h00, 18'(end_at), res);
      issue_op(dscw_pkg::OP_RAW_WRITE, 8'hFF, 18'h3FFFF, res);
      issue_op(dscw_pkg::OP_RAW_WRITE, 8'hA5, 18'(end_at - 1), res);
      issue_op(dscw_pkg::OP_RAW_READ,  8'h00, 18'(end_at - 1), res);
      // first bytes into 1/0 while its map bit is clear
      issue_op(dscw_pkg::OP_WRITE_BYTE, 8'h00, 18'd0, res);
      issue_op(dscw_pkg::OP_WRITE_BYTE, 8'hFF, 18'h3FFFF, res);
      // free bit set with the count already at zero
      issue_op(dscw_pkg::OP_RAW_WRITE,  8'hFF, 18'(map_at + 1), res);
      issue_op(dscw_pkg::OP_END_FILE,   8'h00, 18'd0, res);
      issue_op(dscw_pkg::OP_WRITE_BYTE, 8'h5A, 18'd0, res);
      issue_op(dscw_pkg::OP_RAW_READ,   8'h00, 18'(map_at + 1), res);
      // free bit set with a count to lower
      issue_op(dscw_pkg::OP_RAW_WRITE,  8'h02, 18'(map_at), res);
      issue_op(dscw_pkg::OP_END_FILE,   8'h00, 18'd0, res);
      issue_op(dscw_pkg::OP_WRITE_BYTE, 8'h81, 18'd0, res);
      issue_op(dscw_pkg::OP_RAW_READ,   8'h00, 18'(map_at), res);
      // fill to the last byte, then link on to the next sector
      hdr_at = sector_start(ptr_track, ptr_sector);
      issue_op(dscw_pkg::OP_RAW_WRITE,  8'hFE, 18'(hdr_at + 1), res);
      issue_op(dscw_pkg::OP_WRITE_BYTE, 8'h33, 18'd0, res);
      issue_op(dscw_pkg::OP_WRITE_BYTE, 8'h44, 18'd0, res);
      issue_op(dscw_pkg::OP_RAW_READ,   8'h00, 18'(hdr_at), res);
      issue_op(dscw_pkg::OP_RAW_READ,   8'h00, 18'(hdr_at + 1), res);
      // header that claims a single used byte
      hdr_at = sector_start(ptr_track, ptr_sector);
      issue_op(dscw_pkg::OP_RAW_WRITE,  8'h01, 18'(hdr_at + 1), res);
      issue_op(dscw_pkg::OP_WRITE_BYTE, 8'h77, 18'd0, res);
   endtask

   task automatic test_mixed_traffic(input int count);
      op_outcome_type res;
      int pick;
      logic [7:0] dbyte;
      logic [17:0] addr;
      for (int i = 0; i < count; i++) begin
         pick  = $urandom_range(99);
         dbyte = 8'($urandom);
         addr  = 18'($urandom);
         if (pick < 30)
            issue_op(dscw_pkg::OP_WRITE_BYTE, dbyte, addr, res);
         else if (pick < 50)
            issue_op(dscw_pkg::OP_END_FILE, dbyte, addr, res);
         else if (pick < 65)
            issue_op(dscw_pkg::OP_RAW_READ, dbyte, aim_raw_addr(), res);
         else if (pick < 75)
            issue_op(dscw_pkg::OP_RAW_WRITE, fill_level(),
                     18'(sector_start(ptr_track, ptr_sector) + 1), res);
         else
            issue_op(dscw_pkg::OP_RAW_WRITE,
                     ($urandom_range(1) == 0) ? SECTOR_FULL : dbyte,
                     aim_raw_addr(), res);
      end
   endtask

   // walk the pointer along the chain until the disk has reported full fulls_wanted times or the step limit is hit
   task automatic test_chain_walk(input int fulls_wanted);
      op_outcome_type res;
      int pick, off, fulls, steps;
      logic [7:0] mdata;
      fulls = 0;
      steps = 0;
      while (fulls < fulls_wanted && steps < 600) begin
         pick = $urandom_range(99);
         if (pick < 85) begin
            issue_op(dscw_pkg::OP_END_FILE, 8'($urandom), 18'($urandom), res);
         end else if (pick < 92) begin
            issue_op(dscw_pkg::OP_WRITE_BYTE, 8'($urandom), 18'($urandom), res);
         end else if (pick < 96) begin
            // seed this track's map entry so marking has bits to clear
            off   = $urandom_range(3);
            mdata = (off == 0) ? 8'($urandom_range(3)) :
                    (($urandom_range(3) != 0) ? SECTOR_FULL : 8'($urandom));
            issue_op(dscw_pkg::OP_RAW_WRITE, mdata,
                     18'(sector_start(DIR_TRK, 0) + 4 * ptr_track + off), res);
         end else if (pick < 98) begin
            issue_op(dscw_pkg::OP_RAW_WRITE, fill_level(),
                     18'(sector_start(ptr_track, ptr_sector) + 1), res);
         end else begin
            issue_op(dscw_pkg::OP_RAW_READ, 8'($urandom), aim_raw_addr(), res);
         end
         if (res.status == dscw_pkg::ST_FULL) fulls++;
         steps++;
      end
   endtask

   // result checking
   always @(posedge clock) begin : check_results
      op_outcome_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (outcomes_due.size() == 0) begin
            report_mismatch("result with nothing pending", 32'd0, 32'd1);
         end else begin
            want = outcomes_due.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", want.status, rsp_status);
            if (rsp_read_data !== want.read_data)
               report_mismatch("read_data", want.read_data, rsp_read_data);
            if (rsp_track_now !== want.track)
               report_mismatch("track_now", want.track, rsp_track_now);
            if (rsp_sector_now !== want.sector)
               report_mismatch("sector_now", want.sector, rsp_sector_now);
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid === 1'b1 || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      for (int a = 0; a < IMG_BYTES; a++) img_mirror[a] = 8'h00;
      trk_count_mirror = 35;
      ptr_track        = 1;
      ptr_sector       = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // waits out the clearing pass
      quiesce();

      // reset track count still in force here
      test_directed_ops();

      // track count above the table size is capped
      idle_pct  = 0;
      drain_pct = 0;
      set_track_count(6'd63);
      test_mixed_traffic(60);

      idle_pct  = 76;
      drain_pct = 4;
      set_track_count(6'd39);
      test_mixed_traffic(60);

      // results cannot be held off, so this phase runs without gaps
      idle_pct  = 0;
      drain_pct = 0;
      set_track_count(6'd36);
      test_mixed_traffic(60);

      // last track in use is the directory track, so the walk hops onto track 19
      idle_pct  = 32;
      drain_pct = 2;
      set_track_count(6'd18);
      test_chain_walk(4);
      set_track_count(6'd20);
      test_chain_walk(4);

      // pointer now sits past the tracks in use
      set_track_count(6'd19);
      test_mixed_traffic(40);

      quiesce();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: disk_image_sector_chain_writer_unit.f
rtl/dscw_pkg.sv
rtl/dscw_ctrl.sv
rtl/dscw_datapath.sv
rtl/disk_image_sector_chain_writer_unit.sv
dv/tb_disk_image_sector_chain_writer_unit.sv
